// ----- design/tt_pkg.sv -----
// Shared constants and types for the triangle tangent block.
`default_nettype none
package tt_pkg;
	// Width of the wrapping intermediate arithmetic.
	localparam int ACC_BITS = 64;
	// Components are scaled below 2^NORM_LIMIT before squaring.
	localparam int NORM_LIMIT = 30;

	localparam int POS_BITS_DEF  = 32;
	localparam int UV_BITS_DEF   = 24;
	localparam int FRAC_BITS_DEF = 16;

	typedef logic [ACC_BITS-1:0] acc_t;

	// Corner codes.
	localparam logic [1:0] CORNER_FIRST  = 2'd0;
	localparam logic [1:0] CORNER_SECOND = 2'd1;
	localparam logic [1:0] CORNER_THIRD  = 2'd2;
endpackage
`default_nettype wire

// ----- design/tt_in_if.sv -----
// Corner input channel: valid/ready with one triangle corner as payload.
`default_nettype none
interface tt_in_if #(
	parameter int POS_BITS = 32,
	parameter int UV_BITS  = 24
) ();
	logic                       valid;
	logic                       ready;
	logic [1:0]                 corner;
	logic signed [POS_BITS-1:0] pos_x;
	logic signed [POS_BITS-1:0] pos_y;
	logic signed [POS_BITS-1:0] pos_z;
	logic signed [UV_BITS-1:0]  tex_u;
	logic signed [UV_BITS-1:0]  tex_v;

	modport source (output valid, corner, pos_x, pos_y, pos_z, tex_u, tex_v, input ready);
	modport sink (input valid, corner, pos_x, pos_y, pos_z, tex_u, tex_v, output ready);
endinterface
`default_nettype wire

// ----- design/tt_out_if.sv -----
// Tangent result channel: valid/ready with a unit tangent as payload.
`default_nettype none
interface tt_out_if #(
	parameter int FRAC_BITS = 16
) ();
	logic                        valid;
	logic                        ready;
	logic signed [FRAC_BITS+1:0] tan_x;
	logic signed [FRAC_BITS+1:0] tan_y;
	logic signed [FRAC_BITS+1:0] tan_z;
	logic                        degenerate;

	modport source (output valid, tan_x, tan_y, tan_z, degenerate, input ready);
	modport sink (input valid, tan_x, tan_y, tan_z, degenerate, output ready);
endinterface
`default_nettype wire

// ----- design/tt_mul.sv -----
// Shared signed multiplier with a registered, wrapped 64-bit product.
`default_nettype none
module tt_mul
	import tt_pkg::*;
#(
	parameter int AW = 31,
	parameter int BW = 33
) (
	input  wire logic                 clk,
	input  wire logic signed [AW-1:0] a,
	input  wire logic signed [BW-1:0] b,
	output acc_t                      prod_s1
);
	logic signed [AW+BW-1:0] full;

	assign full = a * b;

	// Product register, wraps to the accumulator width
	always_ff @(posedge clk) begin
		prod_s1 <= ACC_BITS'(full);
	end
endmodule
`default_nettype wire

// ----- design/tt_sqrt.sv -----
// Bit-pair iterative integer square root of a 64-bit radicand.
`default_nettype none
module tt_sqrt
	import tt_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire acc_t radicand,
	output logic [ACC_BITS/2-1:0] root,
	output logic      done_q
);
	localparam int ITER = ACC_BITS / 2;
	localparam int CW   = $clog2(ITER);

	acc_t          n_q;
	acc_t          root_q;
	acc_t          bit_q;
	acc_t          trial;
	logic [CW-1:0] cnt_q;
	logic          busy_q;

	assign trial = root_q + bit_q;
	assign root  = root_q[ACC_BITS/2-1:0];

	// One result bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			n_q    <= '0;
			root_q <= '0;
			bit_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				n_q    <= radicand;
				root_q <= '0;
				bit_q  <= ACC_BITS'(1) << (ACC_BITS - 2);
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (n_q >= trial) begin
					n_q    <= n_q - trial;
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(ITER - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end
endmodule
`default_nettype wire

// ----- design/tt_div.sv -----
// Restoring divider, one quotient bit per cycle, quotient known below 2^QW.
`default_nettype none
module tt_div
	import tt_pkg::*;
#(
	parameter int QW = 17
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	input  wire acc_t    num,
	input  wire acc_t    den,
	output logic [QW-1:0] quo_q,
	output logic         done_q
);
	localparam int CW = $clog2(QW);

	acc_t          rem_q;
	acc_t          d_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          ge;

	assign ge = rem_q >= d_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			d_q    <= '0;
			quo_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q  <= num;
				d_q    <= den << (QW - 1);
				quo_q  <= '0;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (ge) begin
					rem_q <= rem_q - d_q;
				end
				quo_q <= {quo_q[QW-2:0], ge};
				d_q   <= d_q >> 1;
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(QW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end
endmodule
`default_nettype wire

// ----- design/triangle_tangent.sv -----
// Triangle tangent top level: corner store, sequencer and shared multiplier.
// Corners arrive one transfer at a time. Corners 0 and 1 are stored as they
// arrive; corner code three is dropped. Corner 2 starts the computation
// and the block is not ready until the result is loaded into the output
// register: the shared multiplier forms the determinant and the three
// tangent components, the determinant is tested and magnitudes are taken,
// the magnitudes are halved together, with a final check, until every
// component is below 2^30, the multiplier forms the squared length, the
// square root follows, then three divisions, and the output register is
// loaded. A degenerate triangle finishes right after the magnitude step,
// the scaling phase or a zero square root. The load waits while
// an earlier result has not been taken. Results leave through an output
// register, so a waiting result does not stop corners 0 and 1 of the next
// triangle.
`default_nettype none
module triangle_tangent
	import tt_pkg::*;
#(
	parameter int POS_BITS  = POS_BITS_DEF,
	parameter int UV_BITS   = UV_BITS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	tt_in_if.sink     item,
	tt_out_if.source  result
);
	localparam int DW       = UV_BITS + 1;
	localparam int EW       = POS_BITS + 1;
	localparam int MA       = (DW > NORM_LIMIT + 1) ? DW : NORM_LIMIT + 1;
	localparam int MB       = (EW > NORM_LIMIT + 1) ? EW : NORM_LIMIT + 1;
	localparam int OUT_BITS = FRAC_BITS + 2;
	localparam int QW       = FRAC_BITS + 1;
	localparam int RW       = ACC_BITS / 2;

	typedef enum logic [2:0] {
		S_IDLE, S_MUL, S_MAG, S_SHIFT, S_SQR, S_SQRT, S_DIV, S_DONE
	} state_t;

	state_t state_q;

	logic signed [POS_BITS-1:0] hpos_q [6];
	logic signed [UV_BITS-1:0]  htex_q [4];
	logic signed [DW-1:0]       du1_q, dv1_q, du2_q, dv2_q;
	logic signed [EW-1:0]       e1_q [3];
	logic signed [EW-1:0]       e2_q [3];
	logic signed [POS_BITS-1:0] pin [3];
	logic [3:0]                 step_q;
	acc_t                       acc_q, det_q, sum_q;
	acc_t                       comp_q [3];
	acc_t                       mag_q [3];
	logic [2:0]                 neg_q;
	logic [RW-1:0]              len_q;
	logic [OUT_BITS-1:0]        tan_q [3];
	logic                       deg_q;
	logic                       div_go_q;
	logic                       out_valid_q;
	logic [OUT_BITS-1:0]        out_tan_q [3];
	logic                       out_deg_q;

	logic signed [MA-1:0] mul_a;
	logic signed [MB-1:0] mul_b;
	acc_t                 prod_s1;
	acc_t                 mag_sel;
	logic                 sqrt_start;
	logic [RW-1:0]        sqrt_root;
	logic                 sqrt_done;
	acc_t                 div_num, div_den;
	logic [QW-1:0]        div_quo;
	logic                 div_done;
	logic [OUT_BITS-1:0]  quo_ext;
	logic                 any_high, all_zero;
	logic                 accept;

	assign pin[0] = item.pos_x;
	assign pin[1] = item.pos_y;
	assign pin[2] = item.pos_z;

	assign item.ready = (state_q == S_IDLE);
	assign accept     = item.valid && item.ready;

	assign result.valid      = out_valid_q;
	assign result.tan_x      = out_tan_q[0];
	assign result.tan_y      = out_tan_q[1];
	assign result.tan_z      = out_tan_q[2];
	assign result.degenerate = out_deg_q;

	// Selected magnitude for squaring and division
	always_comb begin
		case (step_q[1:0])
			2'd0:    mag_sel = mag_q[0];
			2'd1:    mag_sel = mag_q[1];
			default: mag_sel = mag_q[2];
		endcase
	end

	// Multiplier operand select
	always_comb begin
		mul_a = MA'(du1_q);
		mul_b = MB'(dv2_q);
		if (state_q == S_SQR) begin
			mul_a = MA'($signed({1'b0, mag_sel[NORM_LIMIT-1:0]}));
			mul_b = MB'($signed({1'b0, mag_sel[NORM_LIMIT-1:0]}));
		end else begin
			case (step_q)
				4'd0: begin mul_a = MA'(du1_q); mul_b = MB'(dv2_q); end
				4'd1: begin mul_a = MA'(dv1_q); mul_b = MB'(du2_q); end
				4'd2: begin mul_a = MA'(dv2_q); mul_b = MB'(e1_q[0]); end
				4'd3: begin mul_a = MA'(dv1_q); mul_b = MB'(e2_q[0]); end
				4'd4: begin mul_a = MA'(dv2_q); mul_b = MB'(e1_q[1]); end
				4'd5: begin mul_a = MA'(dv1_q); mul_b = MB'(e2_q[1]); end
				4'd6: begin mul_a = MA'(dv2_q); mul_b = MB'(e1_q[2]); end
				4'd7: begin mul_a = MA'(dv1_q); mul_b = MB'(e2_q[2]); end
				default: begin mul_a = MA'(du1_q); mul_b = MB'(dv2_q); end
			endcase
		end
	end

	tt_mul #(.AW(MA), .BW(MB)) u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_s1(prod_s1)
	);

	assign sqrt_start = (state_q == S_SQR) && (step_q == 4'd3);

	tt_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (sqrt_start),
		.radicand(sum_q + prod_s1),
		.root    (sqrt_root),
		.done_q  (sqrt_done)
	);

	// Round half up: (2*a*2^F + L) / (2*L)
	assign div_num = (mag_sel << (FRAC_BITS + 1)) + ACC_BITS'(len_q);
	assign div_den = ACC_BITS'(len_q) << 1;

	tt_div #(.QW(QW)) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_go_q),
		.num   (div_num),
		.den   (div_den),
		.quo_q (div_quo),
		.done_q(div_done)
	);

	assign quo_ext = OUT_BITS'(div_quo);

	// Scaling status over the three magnitudes
	always_comb begin
		any_high = 1'b0;
		all_zero = 1'b1;
		for (int i = 0; i < 3; i++) begin
			if (mag_q[i][ACC_BITS-1:NORM_LIMIT] != '0) any_high = 1'b1;
			if (mag_q[i] != '0) all_zero = 1'b0;
		end
	end

	// Sequencer, corner store and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			div_go_q    <= 1'b0;
			out_valid_q <= 1'b0;
			deg_q       <= 1'b0;
		end else begin
			// divider start after the root and after each quotient but the last
			div_go_q <= (state_q == S_SQRT && sqrt_done && sqrt_root != '0) ||
				(state_q == S_DIV && div_done && step_q != 4'd2);
			if (result.valid && result.ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (item.corner == CORNER_FIRST || item.corner == CORNER_SECOND) begin
							for (int i = 0; i < 3; i++) begin
								hpos_q[3*item.corner[0]+i] <= pin[i];
							end
							htex_q[2*item.corner[0]]   <= item.tex_u;
							htex_q[2*item.corner[0]+1] <= item.tex_v;
						end else if (item.corner == CORNER_THIRD) begin
							du1_q <= DW'(htex_q[2]) - DW'(htex_q[0]);
							dv1_q <= DW'(htex_q[3]) - DW'(htex_q[1]);
							du2_q <= DW'(item.tex_u) - DW'(htex_q[0]);
							dv2_q <= DW'(item.tex_v) - DW'(htex_q[1]);
							for (int i = 0; i < 3; i++) begin
								e1_q[i] <= EW'(hpos_q[3+i]) - EW'(hpos_q[i]);
								e2_q[i] <= EW'(pin[i]) - EW'(hpos_q[i]);
							end
							step_q  <= '0;
							deg_q   <= 1'b0;
							state_q <= S_MUL;
						end
					end
				end
				S_MUL: begin
					// consume the product issued one step earlier
					step_q <= step_q + 1'b1;
					case (step_q)
						4'd1, 4'd3, 4'd5, 4'd7: acc_q <= prod_s1;
						4'd2: det_q     <= acc_q - prod_s1;
						4'd4: comp_q[0] <= acc_q - prod_s1;
						4'd6: comp_q[1] <= acc_q - prod_s1;
						4'd8: begin
							comp_q[2] <= acc_q - prod_s1;
							state_q   <= S_MAG;
						end
						default: ;
					endcase
				end
				S_MAG: begin
					if (det_q == '0) begin
						deg_q   <= 1'b1;
						state_q <= S_DONE;
					end else begin
						for (int i = 0; i < 3; i++) begin
							mag_q[i] <= comp_q[i][ACC_BITS-1] ? -comp_q[i] : comp_q[i];
							neg_q[i] <= comp_q[i][ACC_BITS-1] ^ det_q[ACC_BITS-1];
						end
						state_q <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					if (all_zero) begin
						deg_q   <= 1'b1;
						state_q <= S_DONE;
					end else if (any_high) begin
						for (int i = 0; i < 3; i++) begin
							mag_q[i] <= mag_q[i] >> 1;
						end
					end else begin
						step_q  <= '0;
						sum_q   <= '0;
						state_q <= S_SQR;
					end
				end
				S_SQR: begin
					step_q <= step_q + 1'b1;
					if (step_q != 4'd0) begin
						sum_q <= sum_q + prod_s1;
					end
					if (step_q == 4'd3) begin
						state_q <= S_SQRT;
					end
				end
				S_SQRT: begin
					if (sqrt_done) begin
						len_q <= sqrt_root;
						if (sqrt_root == '0) begin
							deg_q   <= 1'b1;
							state_q <= S_DONE;
						end else begin
							step_q  <= '0;
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					if (div_done) begin
						tan_q[step_q[1:0]] <= neg_q[step_q[1:0]] ? -quo_ext : quo_ext;
						if (step_q == 4'd2) begin
							state_q <= S_DONE;
						end else begin
							step_q <= step_q + 1'b1;
						end
					end
				end
				S_DONE: begin
					if (!out_valid_q || result.ready) begin
						for (int i = 0; i < 3; i++) begin
							out_tan_q[i] <= deg_q ? '0 : tan_q[i];
						end
						out_deg_q   <= deg_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// A result appears only when the sequencer finishes a triangle
	a_valid_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_DONE)
		else $error("result raised outside the finishing state");

	// A degenerate result carries a zero tangent
	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_deg_q) |->
		(out_tan_q[0] == '0 && out_tan_q[1] == '0 && out_tan_q[2] == '0))
		else $error("degenerate result with nonzero tangent");

	// The x component never exceeds one in magnitude
	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_deg_q) |->
		($signed(out_tan_q[0]) <= $signed(OUT_BITS'(1) << FRAC_BITS) &&
		 $signed(out_tan_q[0]) >= -$signed(OUT_BITS'(1) << FRAC_BITS)))
		else $error("tangent x out of unit range");

	// Squaring starts only on scaled magnitudes
	a_scaled: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SQR) |->
		(mag_q[0][ACC_BITS-1:NORM_LIMIT] == '0 && mag_q[1][ACC_BITS-1:NORM_LIMIT] == '0 &&
		 mag_q[2][ACC_BITS-1:NORM_LIMIT] == '0))
		else $error("squaring unscaled magnitude");
endmodule
`default_nettype wire
